@@ rtl/kes_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kes_pkg
// Shared types and constants for the key event scanner.
// ----------------------------------------------------------------------------
package kes_pkg;

  localparam int KEYS    = 8;
  localparam int FIELD_W = 8;
  localparam int LANES   = (KEYS < FIELD_W) ? KEYS : FIELD_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_FIRST_DELAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK_WINDOW = 2'd3;

  localparam logic [7:0] RST_REPEAT_FIRST_DELAY  = 8'd80;
  localparam logic [7:0] RST_REPEAT_PERIOD       = 8'd10;
  localparam logic [7:0] RST_LONG_PRESS_TICKS    = 8'd120;
  localparam logic [7:0] RST_DOUBLE_CLICK_WINDOW = 8'd50;

  localparam logic [1:0] CLK_IDLE    = 2'd0;
  localparam logic [1:0] CLK_PRESS1  = 2'd1;
  localparam logic [1:0] CLK_RELEASE = 2'd2;
  localparam logic [1:0] CLK_DONE    = 2'd3;

  typedef struct packed {
    logic [7:0] repeat_first_delay;
    logic [7:0] repeat_period;
    logic [7:0] long_press_ticks;
    logic [7:0] double_click_window;
  } cfg_t;

  typedef struct packed {
    logic pressed;
    logic rise_edge;
    logic fall_edge;
    logic long_press;
    logic repeat_pulse;
    logic double_click;
  } lane_out_t;

  function automatic logic [7:0] dec_sat(input logic [7:0] v);
    dec_sat = (v != 8'd0) ? v - 8'd1 : v;
  endfunction

endpackage

@@ rtl/key_event_scanner_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_event_scanner_core
// Scan-tick key event scanner: debounce, edges, long press, auto-repeat and
// sticky double-click latch for up to eight active-low keys.
// ----------------------------------------------------------------------------
//  channel  handshake              word
//  in       in_valid / in_ready    raw_levels, dc_clear_mask
//  out      out_valid / out_ready  pressed, rise_edges, fall_edges,
//                                  long_press, repeat_pulse, double_click
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (cfg_ready always high)
//
//  One word per cycle sustained while out_ready is held; a tick goes through
//  the input register, then through the per-key logic into the result
//  register before its result is valid.
//  The per-key state updates as a word moves from the input register to the
//  result register. A stalled result register holds the input register; if
//  that is empty, it takes one more word. Synchronous reset clears all key
//  state and loads the default timing registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
module key_event_scanner_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    raw_levels,
  input  logic [7:0]                    dc_clear_mask,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    pressed,
  output logic [7:0]                    rise_edges,
  output logic [7:0]                    fall_edges,
  output logic [7:0]                    long_press,
  output logic [7:0]                    repeat_pulse,
  output logic [7:0]                    double_click,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kes_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import kes_pkg::*;

  cfg_t       cfg;
  logic       s1_valid;
  logic [7:0] s1_raw, s1_clr;
  logic       s1_adv;
  lane_out_t  lane_res [FIELD_W];

  kes_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_raw <= raw_levels;
      s1_clr <= dc_clear_mask;
    end
  end

  for (genvar n = 0; n < FIELD_W; n++) begin : g_key
    if (n < LANES) begin : g_lane
      kes_lane u_lane (
        .clk       (clk),
        .rst       (rst),
        .step      (s1_adv),
        .inv_level (~s1_raw[n]),
        .clr       (s1_clr[n]),
        .cfg       (cfg),
        .res       (lane_res[n])
      );
    end else begin : g_none
      assign lane_res[n] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int n = 0; n < FIELD_W; n++) begin
        pressed[n]      <= lane_res[n].pressed;
        rise_edges[n]   <= lane_res[n].rise_edge;
        fall_edges[n]   <= lane_res[n].fall_edge;
        long_press[n]   <= lane_res[n].long_press;
        repeat_pulse[n] <= lane_res[n].repeat_pulse;
        double_click[n] <= lane_res[n].double_click;
      end
    end
  end

  a_rise_fall_disjoint: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((rise_edges & fall_edges) == 8'd0))
    else $error("rise and fall edge on the same key");

  a_events_need_press: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (((rise_edges | long_press | repeat_pulse) & ~pressed) == 8'd0))
    else $error("press event on a released key");

  a_fall_released: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((fall_edges & pressed) == 8'd0))
    else $error("fall edge on a pressed key");

  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> s1_valid)
    else $error("input register word dropped under stall");

endmodule

@@ rtl/kes_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kes_cfg
// Configuration register file: repeat, long press and double-click timing.
// ----------------------------------------------------------------------------
module kes_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kes_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output kes_pkg::cfg_t                 cfg
);
  import kes_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.repeat_first_delay  <= RST_REPEAT_FIRST_DELAY;
      cfg.repeat_period       <= RST_REPEAT_PERIOD;
      cfg.long_press_ticks    <= RST_LONG_PRESS_TICKS;
      cfg.double_click_window <= RST_DOUBLE_CLICK_WINDOW;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_REPEAT_FIRST_DELAY:  cfg.repeat_first_delay  <= cfg_data;
        REG_REPEAT_PERIOD:       cfg.repeat_period       <= cfg_data;
        REG_LONG_PRESS_TICKS:    cfg.long_press_ticks    <= cfg_data;
        REG_DOUBLE_CLICK_WINDOW: cfg.double_click_window <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/kes_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kes_lane
// Per-key state: debounce, timers, repeat, long press, double-click machine.
// ----------------------------------------------------------------------------
module kes_lane (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                inv_level,
  input  logic                clr,
  input  kes_pkg::cfg_t       cfg,
  output kes_pkg::lane_out_t  res
);
  import kes_pkg::*;

  logic       raw_prev, deb_prev, first_done, long_armed, latch;
  logic [7:0] repeat_timer, long_timer, click_timer;
  logic [1:0] click_step;

  logic       first_done_next, long_armed_next, latch_next;
  logic [7:0] repeat_timer_next, long_timer_next, click_timer_next;
  logic [1:0] click_step_next;
  logic       deb, rise, fall, rep, lng;

  always_comb begin
    deb  = raw_prev & inv_level;
    rise = ~deb_prev & deb;
    fall = deb_prev & ~deb;
    rep  = 1'b0;
    lng  = 1'b0;
    latch_next        = latch & ~clr;
    first_done_next   = first_done;
    long_armed_next   = long_armed;
    repeat_timer_next = dec_sat(repeat_timer);
    long_timer_next   = dec_sat(long_timer);
    click_timer_next  = dec_sat(click_timer);
    click_step_next   = click_step;

    if (deb) begin
      if (!first_done) begin
        first_done_next   = 1'b1;
        rep               = 1'b1;
        repeat_timer_next = cfg.repeat_first_delay;
      end else if (repeat_timer_next == 8'd0) begin
        rep               = 1'b1;
        repeat_timer_next = cfg.repeat_period;
      end
      if (long_timer_next == 8'd0 && long_armed) begin
        lng             = 1'b1;
        long_armed_next = 1'b0;
      end
    end else begin
      first_done_next = 1'b0;
      long_timer_next = cfg.long_press_ticks;
      long_armed_next = 1'b1;
    end

    unique case (click_step)
      CLK_IDLE: begin
        if (rise) begin
          click_step_next  = CLK_PRESS1;
          click_timer_next = cfg.double_click_window;
        end
      end
      CLK_PRESS1: begin
        if (fall) begin
          click_step_next  = CLK_RELEASE;
          click_timer_next = cfg.double_click_window;
        end
        if (click_timer_next == 8'd0) click_step_next = CLK_IDLE;
      end
      CLK_RELEASE: begin
        if (rise) click_step_next = CLK_DONE;
        if (click_timer_next == 8'd0) click_step_next = CLK_IDLE;
      end
      default: begin
        latch_next      = 1'b1;
        click_step_next = CLK_IDLE;
      end
    endcase

    res.pressed      = deb;
    res.rise_edge    = rise;
    res.fall_edge    = fall;
    res.long_press   = lng;
    res.repeat_pulse = rep;
    res.double_click = latch_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_prev     <= 1'b0;
      deb_prev     <= 1'b0;
      first_done   <= 1'b0;
      long_armed   <= 1'b0;
      latch        <= 1'b0;
      repeat_timer <= 8'd0;
      long_timer   <= 8'd0;
      click_timer  <= 8'd0;
      click_step   <= CLK_IDLE;
    end else if (step) begin
      raw_prev     <= inv_level;
      deb_prev     <= deb;
      first_done   <= first_done_next;
      long_armed   <= long_armed_next;
      latch        <= latch_next;
      repeat_timer <= repeat_timer_next;
      long_timer   <= long_timer_next;
      click_timer  <= click_timer_next;
      click_step   <= click_step_next;
    end
  end

endmodule
